[src/hcd_pkg.sv]
// Shared types and constants for the chunked body decoder.
package hcd_pkg;

	localparam int SIZE_BITS = 24;

	typedef logic [SIZE_BITS-1:0] size_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_SKIP = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	// Classified body byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} tok_t;

endpackage

[src/hcd_in_if.sv]
// Input channel: one body byte with its stream end flag.
interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       stream_end;

	modport source(output valid, output body_byte, output stream_end, input ready);
	modport sink(input valid, input body_byte, input stream_end, output ready);
endinterface

[src/hcd_out_if.sv]
// Output channel: one decoded result item.
interface hcd_out_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] payload_byte;
	logic       body_done;
	logic       truncated;

	modport source(output valid, output data_valid, output payload_byte,
		output body_done, output truncated, input ready);
	modport sink(input valid, input data_valid, input payload_byte,
		input body_done, input truncated, output ready);
endinterface

[src/http_chunked_body_decoder.sv]
// An accepted byte passes through the queue to the back end, which registers its result item.
// One byte per cycle while the receiver takes results; the chunk state machine updates once per byte.
// A two-entry queue lets the input side keep taking bytes while a result waits.
// Reset (arst_n low) clears the mode to pass-through, the phase to the size line,
// the size and byte counters, the queue and the output valid flag.
module http_chunked_body_decoder (
	input  logic      clk,
	input  logic      arst_n,
	hcd_in_if.sink    in_ch,
	hcd_out_if.source out_ch,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	logic          push;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	hcd_pkg::tok_t in_tok;
	hcd_pkg::tok_t head_tok;

	hcd_front u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.tok    (in_tok)
	);

	hcd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (in_tok),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_tok (head_tok)
	);

	hcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.tok       (head_tok),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

[src/hcd_front.sv]
// Front end: accepts body bytes and classifies them for the decoder.
module hcd_front (
	hcd_in_if.sink          in_ch,
	input  logic            q_full,
	output logic            push,
	output hcd_pkg::tok_t   tok
);

	logic [7:0] b;

	assign b        = in_ch.body_byte;
	assign in_ch.ready = !q_full;
	assign push     = in_ch.valid && !q_full;

	always_comb begin
		tok            = '0;
		tok.data_byte  = b;
		tok.stream_end = in_ch.stream_end;
		tok.is_cr      = (b == hcd_pkg::CHAR_CR);
		tok.is_lf      = (b == hcd_pkg::CHAR_LF);
		case (b) inside
			[8'h30:8'h39]: begin
				tok.is_hex  = 1'b1;
				tok.hex_val = 4'(b - 8'h30);
			end
			[8'h61:8'h66]: begin
				tok.is_hex  = 1'b1;
				tok.hex_val = 4'(b - 8'h57);
			end
			[8'h41:8'h46]: begin
				tok.is_hex  = 1'b1;
				tok.hex_val = 4'(b - 8'h37);
			end
			default: begin
				tok.is_hex  = 1'b0;
				tok.hex_val = 4'd0;
			end
		endcase
	end

endmodule

[src/hcd_fifo.sv]
// Two-entry queue of classified bytes between front and back.
module hcd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hcd_pkg::tok_t push_tok,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output hcd_pkg::tok_t head_tok
);

	hcd_pkg::tok_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/hcd_back.sv]
// Back end: chunk state machine, mode register and output register.
module hcd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          q_empty,
	input  hcd_pkg::tok_t tok,
	output logic          pop,
	hcd_out_if.source     out_ch
);

	logic             mode_q;
	hcd_pkg::phase_t  phase_q, phase_d;
	hcd_pkg::size_t   acc_q, acc_d;
	hcd_pkg::size_t   left_q, left_d;
	hcd_pkg::size_t   left_dec;
	logic             cr_q, cr_d;
	logic             skip_q, skip_d;

	logic             zero_end;
	logic             res_has, res_valid, res_done, res_trunc;
	logic [7:0]       res_byte;

	logic             out_v_q;
	logic             out_dv_q, out_done_q, out_trunc_q;
	logic [7:0]       out_byte_q;

	// Take the head item whenever the output slot is free or draining.
	assign pop      = !q_empty && (!out_v_q || out_ch.ready);
	assign left_dec = left_q - hcd_pkg::size_t'(1);
	assign zero_end = (phase_q == hcd_pkg::PH_SIZE) && tok.is_lf && cr_q
		&& (acc_q == '0);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		left_d  = left_q;
		cr_d    = cr_q;
		skip_d  = skip_q;
		if (mode_q && phase_q != hcd_pkg::PH_DONE) begin
			unique case (phase_q)
				hcd_pkg::PH_SIZE: begin
					if (tok.is_lf && cr_q) begin
						cr_d = 1'b0;
						if (acc_q == '0) begin
							phase_d = hcd_pkg::PH_DONE;
						end else begin
							left_d  = acc_q;
							acc_d   = '0;
							phase_d = hcd_pkg::PH_DATA;
						end
					end else begin
						cr_d = tok.is_cr;
						if (tok.is_hex) begin
							// keep only the low size bits
							acc_d = {acc_q[hcd_pkg::SIZE_BITS-5:0], tok.hex_val};
						end
					end
				end
				hcd_pkg::PH_DATA: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d = hcd_pkg::PH_SKIP;
						skip_d  = 1'b0;
					end
				end
				hcd_pkg::PH_SKIP: begin
					if (!skip_q) begin
						skip_d = 1'b1;
					end else begin
						skip_d  = 1'b0;
						phase_d = hcd_pkg::PH_SIZE;
					end
				end
				default: begin
				end
			endcase
			if (tok.stream_end) begin
				phase_d = hcd_pkg::PH_DONE;
			end
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res_byte  = 8'd0;
		res_done  = 1'b0;
		res_trunc = 1'b0;
		if (!mode_q) begin
			res_valid = 1'b1;
			res_byte  = tok.data_byte;
			res_done  = tok.stream_end;
		end else if (phase_q != hcd_pkg::PH_DONE) begin
			res_valid = (phase_q == hcd_pkg::PH_DATA);
			res_byte  = res_valid ? tok.data_byte : 8'd0;
			res_done  = zero_end || tok.stream_end;
			res_trunc = tok.stream_end && !zero_end;
		end
		res_has = res_valid || res_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			phase_q <= hcd_pkg::PH_SIZE;
			acc_q   <= '0;
			left_q  <= '0;
			cr_q    <= 1'b0;
			skip_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				left_q  <= left_d;
				cr_q    <= cr_d;
				skip_q  <= skip_d;
				out_v_q <= res_has;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_dv_q    <= res_valid;
			out_byte_q  <= res_byte;
			out_done_q  <= res_done;
			out_trunc_q <= res_trunc;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.data_valid   = out_dv_q;
	assign out_ch.payload_byte = out_byte_q;
	assign out_ch.body_done    = out_done_q;
	assign out_ch.truncated    = out_trunc_q;

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && mode_q && phase_q == hcd_pkg::PH_DONE |=> !out_v_q)
		else $error("result issued after end of body");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hcd_pkg::PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_trunc_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_trunc_q |-> out_done_q && mode_q)
		else $error("truncated without body end");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pop && mode_q && phase_q == hcd_pkg::PH_SKIP && !tok.stream_end |=> !out_v_q)
		else $error("result issued for a skipped byte");

endmodule

[verif/http_chunked_body_decoder_tb.sv]
// Self-checking testbench for the HTTP chunked body decoder: directed table, then random streams.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;

	localparam logic MODE_PASS    = 1'b0;
	localparam logic MODE_CHUNKED = 1'b1;

	typedef struct packed {
		logic       dv;
		logic [7:0] pb;
		logic       done;
		logic       trunc;
	} body_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
	} body_item_t;

	typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [7:0]   b;      // body byte, or the mode value on a mode row
		logic         e;
		logic         typed;  // use the result below instead of the predictor
		logic         has;
		body_result_t res;
	} dir_row_t;

	localparam body_result_t NO_RES = '0;

	localparam dir_row_t DIR_ROWS [26] = '{
		// pass-through right after reset
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
		'{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0}},
		'{ROW_BYTE, 8'h5A, 1'b1, 1'b1, 1'b1, '{1'b1, 8'h5A, 1'b1, 1'b0}},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h80, 1'b0, 1'b0}},
		'{ROW_MODE, {7'd0, MODE_CHUNKED}, 1'b0, 1'b0, 1'b0, NO_RES},
		// size line "0x1000003;g" with a lone LF and a stray CR; size wraps to 3
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "x", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "1", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "0", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "3", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, ";", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "g", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, hcd_pkg::CHAR_LF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, hcd_pkg::CHAR_CR, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, "z", 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, hcd_pkg::CHAR_CR, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, hcd_pkg::CHAR_LF, 1'b0, 1'b0, 1'b0, NO_RES},
		// three payload bytes
		'{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
		'{ROW_BYTE, hcd_pkg::CHAR_CR, 1'b0, 1'b1, 1'b1,
			'{1'b1, hcd_pkg::CHAR_CR, 1'b0, 1'b0}},
		// two bytes after the data
		'{ROW_BYTE, hcd_pkg::CHAR_CR, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_BYTE, hcd_pkg::CHAR_LF, 1'b0, 1'b0, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	hcd_in_if  in_ch();
	hcd_out_if out_ch();

	http_chunked_body_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// decoder state as predicted
	logic             mode_q     = MODE_PASS;
	hcd_pkg::phase_t  ph         = hcd_pkg::PH_SIZE;
	hcd_pkg::size_t   size_acc   = '0;
	hcd_pkg::size_t   bytes_left = '0;
	logic             cr_seen    = 1'b0;
	logic             skip_one   = 1'b0;

	body_result_t expected_results[$];
	body_item_t   pending[$];
	int           fail_count = 0;
	int           burst_left = 0;

	// receiver stall control
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          pat_left = 0;
	int          stall_style;
	logic [31:0] stall_bits;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic e,
			output body_result_t r);
		logic [4:0] hx;
		r = '0;
		if (mode_q == MODE_PASS) begin
			r.dv = 1'b1;
			r.pb = b;
			r.done = e;
			return 1'b1;
		end
		if (ph == hcd_pkg::PH_DONE)
			return 1'b0;
		case (ph)
			hcd_pkg::PH_SIZE: begin
				if (b == hcd_pkg::CHAR_LF && cr_seen) begin
					cr_seen = 1'b0;
					if (size_acc == '0) begin
						ph = hcd_pkg::PH_DONE;
						r.done = 1'b1;
					end else begin
						bytes_left = size_acc;
						size_acc = '0;
						ph = hcd_pkg::PH_DATA;
					end
				end else begin
					hx = hex_of(b);
					cr_seen = (b == hcd_pkg::CHAR_CR);
					if (hx[4])
						size_acc = {size_acc[hcd_pkg::SIZE_BITS-5:0], hx[3:0]};
				end
			end
			hcd_pkg::PH_DATA: begin
				r.dv = 1'b1;
				r.pb = b;
				bytes_left = bytes_left - hcd_pkg::size_t'(1);
				if (bytes_left == '0) begin
					ph = hcd_pkg::PH_SKIP;
					skip_one = 1'b0;
				end
			end
			default: begin
				// drop the two bytes after the data unchecked
				if (!skip_one) begin
					skip_one = 1'b1;
				end else begin
					skip_one = 1'b0;
					ph = hcd_pkg::PH_SIZE;
				end
			end
		endcase
		if (e && !r.done) begin
			r.done = 1'b1;
			r.trunc = 1'b1;
			ph = hcd_pkg::PH_DONE;
		end
		return r.dv || r.done;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		logic [4:0] hx;
		do begin
			c = 8'($urandom_range(0, 255));
			hx = hex_of(c);
		end while (hx[4] || c == hcd_pkg::CHAR_CR || c == hcd_pkg::CHAR_LF);
		return c;
	endfunction

	function automatic int pick_chunk_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 16);
		if (roll < 95) return $urandom_range(17, 64);
		return $urandom_range(200, 300);
	endfunction

	task automatic queue_byte(input logic [7:0] c, input logic e);
		pending.push_back(body_item_t'{c, e});
	endtask

	// size line with optional noise, payload, then two trailing bytes
	task automatic queue_chunk(input int size);
		int digits;
		logic [3:0] nib;
		if ($urandom_range(0, 9) == 0) begin
			queue_byte("0", 1'b0);
			queue_byte("x", 1'b0);
		end
		if ($urandom_range(0, 6) == 0)
			queue_byte(hcd_pkg::CHAR_LF, 1'b0);
		digits = 1;
		while ((size >> (4 * digits)) != 0)
			digits++;
		for (int i = digits - 1; i >= 0; i--) begin
			nib = 4'(size >> (4 * i));
			if (nib < 4'd10)
				queue_byte(8'("0" + nib), 1'b0);
			else
				queue_byte(8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10), 1'b0);
			if ($urandom_range(0, 11) == 0) begin
				// CR that is not followed by LF
				queue_byte(hcd_pkg::CHAR_CR, 1'b0);
				queue_byte(noise_char(), 1'b0);
			end
		end
		if ($urandom_range(0, 6) == 0) begin
			queue_byte(";", 1'b0);
			repeat ($urandom_range(1, 4))
				queue_byte(noise_char(), 1'b0);
		end
		queue_byte(hcd_pkg::CHAR_CR, 1'b0);
		queue_byte(hcd_pkg::CHAR_LF, 1'b0);
		repeat (size)
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 6) != 0) begin
			queue_byte(hcd_pkg::CHAR_CR, 1'b0);
			queue_byte(hcd_pkg::CHAR_LF, 1'b0);
		end else begin
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic e, output bit has,
			output body_result_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.body_byte <= b;
		in_ch.stream_end <= e;
		do @(posedge clk); while (!in_ch.ready);
		has = decode_byte(b, e, r);
	endtask

	task automatic send_checked(input logic [7:0] b, input logic e);
		bit has;
		body_result_t r;
		send_item(b, e, has, r);
		if (has)
			expected_results.push_back(r);
	endtask

	task automatic send_pending(input int n);
		body_item_t it;
		repeat (n) begin
			it = pending.pop_front();
			send_checked(it.b, it.e);
		end
	endtask

	task automatic send_passthru(input int n, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			send_checked(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
		end
	endtask

	// write the mode once the block has drained
	task automatic set_mode(input logic m);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_q = m;
	endtask

	// receiver: random stall patterns, plus one long hold on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					stall_style = $urandom_range(0, 2);
					stall_bits = $urandom;
					if (stall_style == 0)
						stall_bits = '1;
					else if (stall_style == 2)
						stall_bits = stall_bits | $urandom;
					pat_left = 32;
				end
				pat_left--;
				out_ch.ready <= stall_bits[pat_left];
			end
		end
	end

	always @(posedge clk) begin
		body_result_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.data_valid, out_ch.payload_byte, out_ch.body_done,
				out_ch.truncated};
			if (expected_results.size() == 0) begin
				$display("%0t: expected no result, got dv=%0b byte=%02h done=%0b trunc=%0b",
					$time, got.dv, got.pb, got.done, got.trunc);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected dv=%0b byte=%02h done=%0b trunc=%0b,",
						$time, want.dv, want.pb, want.done, want.trunc,
						" got dv=%0b byte=%02h done=%0b trunc=%0b",
						got.dv, got.pb, got.done, got.trunc);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		bit has;
		body_result_t r;
		int split;
		int base;
		int cut;
		int wait_cycles;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.body_byte = 8'h00;
		in_ch.stream_end = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_MODE) begin
				set_mode(DIR_ROWS[i].b[0]);
			end else begin
				send_item(DIR_ROWS[i].b, DIR_ROWS[i].e, has, r);
				if (DIR_ROWS[i].typed) begin
					if (DIR_ROWS[i].has)
						expected_results.push_back(DIR_ROWS[i].res);
				end else if (has) begin
					expected_results.push_back(r);
				end
			end
		end

		// long chunked body, interrupted by a pass-through stretch mid-stream
		while (pending.size() < 700)
			queue_chunk(pick_chunk_size());
		split = $urandom_range(300, 420);
		send_pending(split);
		set_mode(MODE_PASS);
		send_passthru(200, 40);
		set_mode(MODE_CHUNKED);
		send_pending(pending.size());

		// close the body: zero-size line or early stream end
		if ($urandom_range(0, 1)) begin
			queue_byte("0", 1'b0);
			if ($urandom_range(0, 1))
				queue_byte("0", 1'b0);
			queue_byte(hcd_pkg::CHAR_CR, 1'b0);
			queue_byte(hcd_pkg::CHAR_LF, $urandom_range(0, 1));
		end else begin
			base = pending.size();
			queue_chunk(pick_chunk_size());
			cut = $urandom_range(base, pending.size() - 1);
			pending[cut].e = 1'b1;
			while (pending.size() > cut + 1)
				void'(pending.pop_back());
		end
		// bytes after the end give nothing
		repeat (6)
			queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1));
		send_pending(pending.size());

		set_mode(MODE_PASS);
		send_passthru(150, -1);
		set_mode(MODE_CHUNKED);
		repeat (6)
			send_checked(8'($urandom_range(0, 255)), $urandom_range(0, 1));

		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
